// File: rtl/core/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared sizes and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = CNT_W + 1;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OP_W   = 4;
  localparam int unsigned ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 4'd2;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 4'd3;
  localparam logic [OP_W-1:0] OP_LENGTH    = 4'd4;
  localparam logic [OP_W-1:0] OP_CONTAINS  = 4'd5;
  localparam logic [OP_W-1:0] OP_REM_FIRST = 4'd6;
  localparam logic [OP_W-1:0] OP_REM_EVEN  = 4'd7;
  localparam logic [OP_W-1:0] OP_REM_MAX   = 4'd8;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// File: rtl/core/ole_in_if.sv
// ----------------------------------------------------------------------------
// ole_in_if
// Command channel: operation code and operand value.
// ----------------------------------------------------------------------------
interface ole_in_if;
  logic                              valid;
  logic                              ready;
  logic [ole_pkg::OP_W-1:0]          operation;
  logic signed [ole_pkg::VAL_W-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// File: rtl/core/ole_out_if.sv
// ----------------------------------------------------------------------------
// ole_out_if
// Response channel: removed value, status, entry count and found flag.
// ----------------------------------------------------------------------------
interface ole_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ole_pkg::VAL_W-1:0]  result_value;
  logic [ole_pkg::ST_W-1:0]          status;
  logic [ole_pkg::CNT_W-1:0]         entry_count;
  logic                              found;

  modport source (output valid, output result_value, output status,
                  output entry_count, output found, input ready);
  modport sink   (input valid, input result_value, input status,
                  input entry_count, input found, output ready);
endinterface

// File: rtl/core/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded deque of signed 32-bit values with search and in-place removal.
// ----------------------------------------------------------------------------
// Entries live in one RAM used as a ring (head pointer plus count), so front
// and back inserts and removes touch a single entry. One command word is
// worked at a time; the next is accepted as soon as the previous response
// is staged, even if that response has not been taken yet. Inserts, length and
// unused codes go straight to the response; front/back removes read one entry
// first; contains scans until a hit or the last entry; remove-first scans to
// the hit, then closes the gap; remove-max scans every entry, then closes the
// gap; remove-even compacts the entries it keeps. Scans and compaction are
// paced by the RAM's single read port, which moves one entry per cycle. No
// clearing pass runs after reset.
module ordered_list_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  ole_in_if.sink           in_i,
  ole_out_if.source        out_o
);

  localparam int unsigned AW = ole_pkg::ADDR_W;
  localparam int unsigned CW = ole_pkg::CNT_W;
  localparam int unsigned IW = ole_pkg::IDX_W;
  localparam int unsigned VW = ole_pkg::VAL_W;
  localparam logic [AW:0]   DepthA = (AW + 1)'(ole_pkg::DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(ole_pkg::DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(ole_pkg::DEPTH - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_RDWAIT  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_COMPACT = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [IW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l[AW-1:0]};
    if (s >= DepthA) begin
      s = s - DepthA;
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]                 state_q, state_d;
  logic [ole_pkg::OP_W-1:0]   op_q, op_d;
  logic [VW-1:0]              val_q, val_d;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [IW-1:0]              chk_idx_q, chk_idx_d;
  logic [IW-1:0]              pos_q, pos_d;
  logic signed [VW-1:0]       max_q, max_d;
  logic [VW-1:0]              rv_q, rv_d;
  logic [ole_pkg::ST_W-1:0]   st_q, st_d;
  logic                       fnd_q, fnd_d;
  logic                       out_vld_q, out_vld_d;
  logic [VW-1:0]              out_val_q, out_val_d;
  logic [ole_pkg::ST_W-1:0]   out_st_q, out_st_d;
  logic [CW-1:0]              out_cnt_q, out_cnt_d;
  logic                       out_fnd_q, out_fnd_d;

  logic                       mem_we;
  logic [IW-1:0]              rd_lidx, wr_lidx;
  logic [VW-1:0]              mem_wdata, mem_rdata;
  logic [AW-1:0]              mem_raddr, mem_waddr;

  logic [IW-1:0]              cnt_x;
  logic                       in_acc;
  logic                       hit, last, newmax, even_op;
  logic [IW-1:0]              del_pos;
  logic [CW:0]                half_cnt;

  assign cnt_x    = {1'b0, cnt_q};
  assign in_acc   = in_i.valid & in_i.ready;
  assign hit      = (mem_rdata == val_q);
  assign last     = (chk_idx_q == (cnt_x - 1'b1));
  assign newmax   = (chk_idx_q == '0) || ($signed(mem_rdata) > max_q);
  assign del_pos  = newmax ? chk_idx_q : pos_q;
  assign even_op  = (op_q == ole_pkg::OP_REM_EVEN);
  assign half_cnt = ({1'b0, cnt_q} + 1'b1) >> 1;

  assign mem_raddr = phys(head_q, rd_lidx);
  assign mem_waddr = phys(head_d, wr_lidx);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    pos_d     = pos_q;
    max_d     = max_q;
    rv_d      = rv_q;
    st_d      = st_q;
    fnd_d     = fnd_q;
    out_vld_d = out_vld_q & ~out_o.ready;
    out_val_d = out_val_q;
    out_st_d  = out_st_q;
    out_cnt_d = out_cnt_q;
    out_fnd_d = out_fnd_q;
    mem_we    = 1'b0;
    mem_wdata = val_q;
    rd_lidx   = '0;
    wr_lidx   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = in_i.operation;
          val_d   = in_i.value;
          rv_d    = '0;
          st_d    = ole_pkg::ST_OK;
          fnd_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d   = S_FINISH;
        idx_d     = '0;
        chk_vld_d = 1'b0;
        case (op_q)
          ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK: begin
            if (cnt_q == DepthC) begin
              st_d = ole_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
              if (op_q == ole_pkg::OP_INS_FRONT) begin
                head_d = (head_q == '0) ? LastA : head_q - 1'b1;
              end else begin
                wr_lidx = cnt_x;
              end
            end
          end
          ole_pkg::OP_REM_FRONT, ole_pkg::OP_REM_BACK: begin
            if (cnt_q == '0) begin
              st_d = ole_pkg::ST_EMPTY;
            end else begin
              rd_lidx = (op_q == ole_pkg::OP_REM_FRONT) ? '0 : cnt_x - 1'b1;
              state_d = S_RDWAIT;
            end
          end
          ole_pkg::OP_CONTAINS: begin
            if (cnt_q == '0) begin
              st_d = ole_pkg::ST_NOTFOUND;
            end else begin
              state_d = S_SCAN;
            end
          end
          ole_pkg::OP_REM_FIRST, ole_pkg::OP_REM_MAX: begin
            if (cnt_q == '0) begin
              st_d = ole_pkg::ST_EMPTY;
            end else begin
              state_d = S_SCAN;
            end
          end
          ole_pkg::OP_REM_EVEN: begin
            if (cnt_q == '0) begin
              st_d = ole_pkg::ST_EMPTY;
            end else begin
              idx_d   = IW'(2);
              state_d = S_COMPACT;
            end
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        rv_d  = mem_rdata;
        cnt_d = cnt_q - 1'b1;
        if (op_q == ole_pkg::OP_REM_FRONT) begin
          head_d = (head_q == LastA) ? '0 : head_q + 1'b1;
        end
        state_d = S_FINISH;
      end

      S_SCAN: begin
        if (idx_q < cnt_x) begin
          rd_lidx   = idx_q;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          case (op_q)
            ole_pkg::OP_CONTAINS: begin
              if (hit) begin
                fnd_d   = 1'b1;
                state_d = S_FINISH;
              end else if (last) begin
                st_d    = ole_pkg::ST_NOTFOUND;
                state_d = S_FINISH;
              end
            end
            ole_pkg::OP_REM_FIRST: begin
              if (hit) begin
                fnd_d     = 1'b1;
                rv_d      = val_q;
                idx_d     = chk_idx_q + 1'b1;
                chk_vld_d = 1'b0;
                state_d   = S_COMPACT;
              end else if (last) begin
                st_d    = ole_pkg::ST_NOTFOUND;
                state_d = S_FINISH;
              end
            end
            default: begin
              if (newmax) begin
                max_d = $signed(mem_rdata);
                pos_d = chk_idx_q;
              end
              if (last) begin
                rv_d      = newmax ? mem_rdata : max_q;
                idx_d     = del_pos + 1'b1;
                chk_vld_d = 1'b0;
                state_d   = S_COMPACT;
              end
            end
          endcase
        end
      end

      S_COMPACT: begin
        if (chk_vld_q) begin
          mem_we    = 1'b1;
          wr_lidx   = chk_idx_q;
          mem_wdata = mem_rdata;
        end
        if (idx_q < cnt_x) begin
          rd_lidx   = idx_q;
          chk_vld_d = 1'b1;
          chk_idx_d = even_op ? (idx_q >> 1) : idx_q - 1'b1;
          idx_d     = idx_q + (even_op ? IW'(2) : IW'(1));
        end else begin
          chk_vld_d = 1'b0;
          if (!chk_vld_q) begin
            cnt_d   = even_op ? half_cnt[CW-1:0] : cnt_q - 1'b1;
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_val_d = rv_q;
          out_st_d  = st_q;
          out_cnt_d = cnt_q;
          out_fnd_d = fnd_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ole_ram #(
    .Width (VW),
    .Depth (ole_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    pos_q     <= pos_d;
    max_q     <= max_d;
    rv_q      <= rv_d;
    st_q      <= st_d;
    fnd_q     <= fnd_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
    out_fnd_q <= out_fnd_d;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_st_q;
  assign out_o.entry_count  = out_cnt_q;
  assign out_o.found        = out_fnd_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count above depth");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_resp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_FINISH))
    else $error("response staged outside finish");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC) && (cnt_q == $past(cnt_q)))
    else $error("accepted word not dispatched");
`endif

endmodule
